### rtl/assert_macros.svh
// Assertion macros for the differential drive velocity command block.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while in reset
`define DDVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds
`define DDVC_NEVER(lbl, cond, msg) \
  `DDVC_ASSERT(lbl, !(cond), msg)

`endif

### rtl/ddvc_pkg.sv
// Shared types, register indexes, reset values and the clamp function
// for the differential drive velocity command block. No dependencies.
package ddvc_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LINEAR    = 4'd0,
    REG_MAX_ANGULAR   = 4'd1,
    REG_LIN_JUMP_LIM  = 4'd2,
    REG_ANG_JUMP_LIM  = 4'd3,
    REG_JUMP_HOLD     = 4'd4,
    REG_HALF_TRACK    = 4'd5,
    REG_WHEEL_LIMIT   = 4'd6,
    REG_RPM_SCALE     = 4'd7
  } ddvc_reg_t;

  // Register reset values
  localparam logic [12:0] RstMaxLinear   = 13'd2048;
  localparam logic [12:0] RstMaxAngular  = 13'd3072;
  localparam logic [13:0] RstLinJumpLim  = 14'd2048;
  localparam logic [13:0] RstAngJumpLim  = 14'd2048;
  localparam logic [7:0]  RstJumpHold    = 8'd40;
  localparam logic [9:0]  RstHalfTrack   = 10'd315;
  localparam logic [12:0] RstWheelLimit  = 13'd2048;
  localparam logic [15:0] RstRpmScale    = 16'd47498;

  // Per-axis filter settings
  typedef struct packed {
    logic [12:0] max_cmd;
    logic [13:0] jump_limit;
    logic [7:0]  hold;
  } ddvc_axis_cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_MUL_T,
    S_WHEEL,
    S_MUL_L,
    S_MUL_R,
    S_DONE
  } ddvc_state_t;

  // Clamp to +/-m, zero values within one LSB of zero
  function automatic logic signed [13:0] clamp_db(input logic signed [15:0] x,
                                                  input logic [12:0] m);
    logic signed [15:0] ms;
    logic signed [15:0] nms;
    logic signed [13:0] r;
    ms  = $signed({3'b000, m});
    nms = -ms;
    if (x > ms) begin
      r = ms[13:0];
    end else if (x < nms) begin
      r = nms[13:0];
    end else if (x >= -16'sd1 && x <= 16'sd1) begin
      r = '0;
    end else begin
      r = x[13:0];
    end
    return r;
  endfunction

endpackage

### rtl/ddvc_axis.sv
// One command axis: clamp with deadband, then the jump filter with its
// previous value and jump counter. Depends on ddvc_pkg.
module ddvc_axis (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic signed [15:0]      cmd,
  input  ddvc_pkg::ddvc_axis_cfg_t cfg,
  output logic signed [13:0]      filt
);

  logic signed [13:0] prev_r, prev_nxt;
  logic [8:0]         cnt_r, cnt_nxt;
  logic signed [13:0] v;
  logic signed [14:0] diff;
  logic [14:0]        mag;
  logic               jump;

  // Clamp and measure the step against the previous value
  always_comb begin
    v    = ddvc_pkg::clamp_db(cmd, cfg.max_cmd);
    diff = $signed({prev_r[13], prev_r}) - $signed({v[13], v});
    mag  = diff[14] ? 15'(-diff) : 15'(diff);
    jump = mag > {1'b0, cfg.jump_limit};
  end

  // Count jumps; reject once the count passes the hold value
  always_comb begin
    filt    = v;
    cnt_nxt = cnt_r;
    if (jump) begin
      if (cnt_r > {1'b0, cfg.hold}) begin
        cnt_nxt = '0;
        filt    = prev_r;
      end else begin
        cnt_nxt = cnt_r + 9'd1;
      end
    end
    prev_nxt = filt;
  end

  // Advance filter state once per drive request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      cnt_r  <= '0;
    end else if (upd) begin
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/ddvc_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// No package dependencies.
module ddvc_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] a,
  input  logic [15:0]        b,
  output logic signed [32:0] p
);

  logic signed [32:0] p_r, p_nxt;

  assign p_nxt = a * $signed({1'b0, b});

  // Hold the product until the next enabled step
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

### rtl/diff_drive_velocity_command.sv
// Top level of the differential drive velocity command block: registers,
// sequencer and wheel datapath. Depends on ddvc_pkg, ddvc_axis, ddvc_mul
// and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall): one request per control tick with
//    linear and angular speed commands and a stop flag.
//  - Output channel (out_valid / out_stall): exactly one result per request,
//    carrying left/right rpm and the drive_valid, torque_off, brake_release
//    flags.
//  - Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
//    indexes beyond the register list are ignored. Write only while idle.
//  - A drive request walks filter, three passes through one shared multiplier
//    (turn term, left rpm, right rpm) and a wheel clamp step, in the states
//    FILT, MUL_T, WHEEL, MUL_L, MUL_R and DONE; the result loads from DONE and
//    the next request is taken back in IDLE. A stop request skips to DONE.
//  - in_stall is high while a request is in work. A finished result waits in
//    the output register; while it is stalled, the next request is still
//    accepted and runs until its own result is ready to load.
//  - Synchronous reset clears the filter state, the sequencer and out_valid
//    and reloads the register reset values.
`include "assert_macros.svh"

module diff_drive_velocity_command (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_linear_cmd,
  input  logic signed [15:0]               in_angular_cmd,
  input  logic                             in_stop_request,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_left_rpm,
  output logic signed [15:0]               out_right_rpm,
  output logic                             out_drive_valid,
  output logic                             out_torque_off,
  output logic                             out_brake_release,
  // configuration port
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddvc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ddvc_pkg::CfgDataW-1:0]    cfg_data
);

  // Configuration registers
  logic [12:0] max_linear_r, max_angular_r, wheel_limit_r;
  logic [13:0] lin_jump_lim_r, ang_jump_lim_r;
  logic [7:0]  jump_hold_r;
  logic [9:0]  half_track_r;
  logic [15:0] rpm_scale_r;

  // Sequencer and datapath
  ddvc_pkg::ddvc_state_t state_r, state_nxt;
  logic               in_acc, out_free, out_load;
  logic               stop_r;
  logic signed [15:0] lin_cmd_r, ang_cmd_r;
  logic signed [13:0] lin_filt, ang_filt;
  logic signed [13:0] lin_f_r, ang_f_r;
  logic signed [13:0] left_w_r, right_w_r;
  logic signed [15:0] lrpm_r;
  logic               axis_upd, mul_en, ld_filt, ld_wheel, ld_lrpm;
  logic signed [15:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [32:0] prod;
  logic signed [32:0] t_bias, t_full, r_bias, r_full;
  logic signed [15:0] turn, sum_l, sum_r, rpm_sat, lrpm_neg;
  ddvc_pkg::ddvc_axis_cfg_t lin_cfg, ang_cfg;

  logic               out_valid_r;
  logic signed [15:0] out_left_r, out_right_r;
  logic               out_drive_r, out_torque_r, out_brake_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ddvc_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_linear_r   <= ddvc_pkg::RstMaxLinear;
      max_angular_r  <= ddvc_pkg::RstMaxAngular;
      lin_jump_lim_r <= ddvc_pkg::RstLinJumpLim;
      ang_jump_lim_r <= ddvc_pkg::RstAngJumpLim;
      jump_hold_r    <= ddvc_pkg::RstJumpHold;
      half_track_r   <= ddvc_pkg::RstHalfTrack;
      wheel_limit_r  <= ddvc_pkg::RstWheelLimit;
      rpm_scale_r    <= ddvc_pkg::RstRpmScale;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ddvc_pkg::REG_MAX_LINEAR:   max_linear_r   <= cfg_data[12:0];
        ddvc_pkg::REG_MAX_ANGULAR:  max_angular_r  <= cfg_data[12:0];
        ddvc_pkg::REG_LIN_JUMP_LIM: lin_jump_lim_r <= cfg_data[13:0];
        ddvc_pkg::REG_ANG_JUMP_LIM: ang_jump_lim_r <= cfg_data[13:0];
        ddvc_pkg::REG_JUMP_HOLD:    jump_hold_r    <= cfg_data[7:0];
        ddvc_pkg::REG_HALF_TRACK:   half_track_r   <= cfg_data[9:0];
        ddvc_pkg::REG_WHEEL_LIMIT:  wheel_limit_r  <= cfg_data[12:0];
        ddvc_pkg::REG_RPM_SCALE:    rpm_scale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Axis filters
  assign lin_cfg = '{max_cmd: max_linear_r, jump_limit: lin_jump_lim_r, hold: jump_hold_r};
  assign ang_cfg = '{max_cmd: max_angular_r, jump_limit: ang_jump_lim_r, hold: jump_hold_r};

  ddvc_axis u_lin (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (axis_upd),
    .cmd   (lin_cmd_r),
    .cfg   (lin_cfg),
    .filt  (lin_filt)
  );

  ddvc_axis u_ang (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (axis_upd),
    .cmd   (ang_cmd_r),
    .cfg   (ang_cfg),
    .filt  (ang_filt)
  );

  // Shared multiplier
  ddvc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddvc_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_stop_request ? ddvc_pkg::S_DONE : ddvc_pkg::S_FILT;
        end
      end
      ddvc_pkg::S_FILT:  state_nxt = ddvc_pkg::S_MUL_T;
      ddvc_pkg::S_MUL_T: state_nxt = ddvc_pkg::S_WHEEL;
      ddvc_pkg::S_WHEEL: state_nxt = ddvc_pkg::S_MUL_L;
      ddvc_pkg::S_MUL_L: state_nxt = ddvc_pkg::S_MUL_R;
      ddvc_pkg::S_MUL_R: state_nxt = ddvc_pkg::S_DONE;
      ddvc_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ddvc_pkg::S_IDLE;
        end
      end
      default: state_nxt = ddvc_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    axis_upd = 1'b0;
    mul_en   = 1'b0;
    ld_filt  = 1'b0;
    ld_wheel = 1'b0;
    ld_lrpm  = 1'b0;
    out_load = 1'b0;
    mul_a    = $signed({{2{ang_f_r[13]}}, ang_f_r});
    mul_b    = {6'd0, half_track_r};
    case (state_r)
      ddvc_pkg::S_FILT: begin
        axis_upd = 1'b1;
        ld_filt  = 1'b1;
      end
      ddvc_pkg::S_MUL_T: begin
        mul_en = 1'b1;
      end
      ddvc_pkg::S_WHEEL: begin
        ld_wheel = 1'b1;
      end
      ddvc_pkg::S_MUL_L: begin
        mul_en = 1'b1;
        mul_a  = $signed({{2{left_w_r[13]}}, left_w_r});
        mul_b  = rpm_scale_r;
      end
      ddvc_pkg::S_MUL_R: begin
        mul_en  = 1'b1;
        ld_lrpm = 1'b1;
        mul_a   = $signed({{2{right_w_r[13]}}, right_w_r});
        mul_b   = rpm_scale_r;
      end
      ddvc_pkg::S_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Turn term and wheel sums, truncated toward zero
  always_comb begin
    t_bias = prod + (prod[32] ? 33'sd1023 : 33'sd0);
    t_full = t_bias >>> 10;
    turn   = t_full[15:0];
    sum_l  = $signed({{2{lin_f_r[13]}}, lin_f_r}) + turn;
    sum_r  = $signed({{2{lin_f_r[13]}}, lin_f_r}) - turn;
  end

  // Rpm from the current product, truncated toward zero and saturated
  always_comb begin
    r_bias = prod + (prod[32] ? 33'sd16383 : 33'sd0);
    r_full = r_bias >>> 14;
    if (r_full > 33'sd32767) begin
      rpm_sat = 16'sh7FFF;
    end else if (r_full < -33'sd32768) begin
      rpm_sat = -16'sh8000;
    end else begin
      rpm_sat = r_full[15:0];
    end
    lrpm_neg = (rpm_sat == -16'sh8000) ? 16'sh7FFF : -rpm_sat;
  end

  // Sequencer state and flow control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddvc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stop_r    <= in_stop_request;
      lin_cmd_r <= in_linear_cmd;
      ang_cmd_r <= in_angular_cmd;
    end
    if (ld_filt) begin
      lin_f_r <= lin_filt;
      ang_f_r <= ang_filt;
    end
    if (ld_wheel) begin
      left_w_r  <= ddvc_pkg::clamp_db(sum_l, wheel_limit_r);
      right_w_r <= ddvc_pkg::clamp_db(sum_r, wheel_limit_r);
    end
    if (ld_lrpm) begin
      lrpm_r <= lrpm_neg;
    end
    if (out_load) begin
      out_left_r   <= stop_r ? 16'sd0 : lrpm_r;
      out_right_r  <= stop_r ? 16'sd0 : rpm_sat;
      out_drive_r  <= !stop_r;
      out_torque_r <= stop_r;
      out_brake_r  <= stop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_rpm      = out_left_r;
  assign out_right_rpm     = out_right_r;
  assign out_drive_valid   = out_drive_r;
  assign out_torque_off    = out_torque_r;
  assign out_brake_release = out_brake_r;

  // Checks
  `DDVC_ASSERT(a_stop_direct, (in_acc && in_stop_request) |=> (state_r == ddvc_pkg::S_DONE), "stop request did not go straight to result")
  `DDVC_ASSERT(a_load_in_done, $rose(out_valid_r) |-> $past(state_r == ddvc_pkg::S_DONE), "result raised outside the done step")
  `DDVC_NEVER(a_flags_excl, out_valid_r && out_drive_valid && out_torque_off, "drive and torque off issued together")

endmodule
